@@ hw/rtl/tcqb_pkg.sv @@
// Shared types, constants and helper functions for the two-class queue bank.
package tcqb_pkg;

    // Bank geometry
    localparam int NUM_QUEUES  = 16;
    localparam int QUEUE_DEPTH = 8;
    localparam int TAG_BITS    = 16;

    // Fixed port field widths
    localparam int CMD_W       = 2;
    localparam int QUEUE_IDX_W = 4;
    localparam int TAG_IN_W    = 16;
    localparam int CODE_W      = 2;
    localparam int FILL_W      = 4;

    // Derived widths
    localparam int QSEL_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ENTRY_W     = TAG_BITS + 1;

    typedef logic [QSEL_W-1:0]  qsel_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    // Stored entry: urgency mark above the tag
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_TAIL = 2'd0,
        CMD_ADD_HEAD = 2'd1,
        CMD_SERVE    = 2'd2
    } cmd_t;

    typedef enum logic [CODE_W-1:0] {
        RES_DONE  = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } res_t;

    // Per-command plan from the queue controller to the datapath
    typedef struct packed {
        res_t   code;
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
        logic   rd_en;
        addr_t  rd_addr;
        cnt_t   fill;
    } plan_t;

    // Fold a raw queue index onto the bank (small constant table)
    function automatic qsel_t wrap_queue(input logic [QUEUE_IDX_W-1:0] idx);
        qsel_t r;
        r = '0;
        for (int i = 0; i < (1 << QUEUE_IDX_W); i++) begin
            if (idx == QUEUE_IDX_W'(i)) begin
                r = QSEL_W'(i % NUM_QUEUES);
            end
        end
        return r;
    endfunction

    // Ring slot after s
    function automatic slot_t next_slot(input slot_t s);
        return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    // Ring slot before s
    function automatic slot_t prev_slot(input slot_t s);
        return (s == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : s - SLOT_W'(1);
    endfunction

    // Slot n places past the head, with one wrap
    function automatic slot_t tail_slot(input slot_t h, input cnt_t n);
        logic [SLOT_W:0] sum;
        sum = {1'b0, h} + (SLOT_W + 1)'(n);
        if (sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (SLOT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Flat store address of a queue slot
    function automatic addr_t store_addr(input qsel_t q, input slot_t s);
        return ADDR_W'(int'(q) * QUEUE_DEPTH + int'(s));
    endfunction

    // Fill count onto the fixed-width port field
    function automatic logic [FILL_W-1:0] fill_field(input cnt_t n);
        logic [CNT_W+FILL_W-1:0] w;
        w = '0;
        w[CNT_W-1:0] = n;
        return w[FILL_W-1:0];
    endfunction

    // Port tag to stored tag width
    function automatic tag_t tag_to_store(input logic [TAG_IN_W-1:0] t);
        logic [TAG_BITS+TAG_IN_W-1:0] w;
        w = '0;
        w[TAG_IN_W-1:0] = t;
        return w[TAG_BITS-1:0];
    endfunction

    // Stored tag to port width
    function automatic logic [TAG_IN_W-1:0] tag_to_port(input tag_t t);
        logic [TAG_BITS+TAG_IN_W-1:0] w;
        w = '0;
        w[TAG_BITS-1:0] = t;
        return w[TAG_IN_W-1:0];
    endfunction

endpackage

@@ hw/rtl/two_class_queue_bank_top.sv @@
// Top level of the two-class queue bank: input stage, entry store, result stage.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_ready | command, queue_index, entry_tag
//  out     | out_valid/out_ready | result_code, served_tag, served_urgent, fill_after
//
// One command per cycle sustained while results are taken; a result passes the input register,
// then the result register alongside the entry store's registered read.
// Each queue is a ring in the shared entry store with its own head and fill count.
// Reset clears all fill counts and heads; the entry store needs no clearing.
// A stalled result holds both stages; the input side keeps taking a command while
// its register is empty or the result stage is moving.
module two_class_queue_bank_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tcqb_pkg::CMD_W-1:0]         command,
    input  logic [tcqb_pkg::QUEUE_IDX_W-1:0]   queue_index,
    input  logic [tcqb_pkg::TAG_IN_W-1:0]      entry_tag,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tcqb_pkg::CODE_W-1:0]        result_code,
    output logic [tcqb_pkg::TAG_IN_W-1:0]      served_tag,
    output logic                               served_urgent,
    output logic [tcqb_pkg::FILL_W-1:0]        fill_after
);
    import tcqb_pkg::*;

    // Input stage
    logic                   s1_valid_reg;
    logic [CMD_W-1:0]       s1_cmd_reg;
    logic [QUEUE_IDX_W-1:0] s1_queue_reg;
    logic [TAG_IN_W-1:0]    s1_tag_reg;

    // Result stage
    logic                   out_valid_reg;
    res_t                   out_code_reg;
    logic                   out_hit_reg;
    cnt_t                   out_fill_reg;
    entry_t                 rd_data_reg;

    entry_t                 entry_mem [STORE_DEPTH];

    logic                   advance;
    logic                   step;
    plan_t                  plan;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = advance && s1_valid_reg;
    assign in_ready = !s1_valid_reg || advance;

    // Capture a command on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_cmd_reg   <= command;
            s1_queue_reg <= queue_index;
            s1_tag_reg   <= entry_tag;
        end
    end

    tcqb_queue_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd_t'(s1_cmd_reg)),
        .qsel  (wrap_queue(s1_queue_reg)),
        .tag   (tag_to_store(s1_tag_reg)),
        .plan  (plan)
    );

    // Write added entries, read the head on a serve
    always_ff @(posedge clk)
    begin
        if (step && plan.wr_en) begin
            entry_mem[plan.wr_addr] <= plan.wr_data;
        end
        if (step && plan.rd_en) begin
            rd_data_reg <= entry_mem[plan.rd_addr];
        end
    end

    // Advance the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            out_code_reg <= plan.code;
            out_hit_reg  <= plan.rd_en;
            out_fill_reg <= plan.fill;
        end
    end

    // Drive the result fields; served fields are zero unless a serve hit
    assign out_valid     = out_valid_reg;
    assign result_code   = out_code_reg;
    assign served_tag    = out_hit_reg ? tag_to_port(rd_data_reg[TAG_BITS-1:0]) : '0;
    assign served_urgent = out_hit_reg & rd_data_reg[TAG_BITS];
    assign fill_after    = fill_field(out_fill_reg);

endmodule

@@ hw/rtl/tcqb_queue_ctrl.sv @@
// Per-queue head pointers and fill counts, and the command decision.
module tcqb_queue_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  tcqb_pkg::cmd_t  cmd,
    input  tcqb_pkg::qsel_t qsel,
    input  tcqb_pkg::tag_t  tag,
    output tcqb_pkg::plan_t plan
);
    import tcqb_pkg::*;

    slot_t head_reg  [NUM_QUEUES];
    cnt_t  count_reg [NUM_QUEUES];

    slot_t head_cur;
    cnt_t  count_cur;
    slot_t head_next;
    logic  full;
    logic  empty;

    // Decide the command against the addressed queue
    always_comb
    begin
        head_cur  = head_reg[qsel];
        count_cur = count_reg[qsel];
        full      = (count_cur == CNT_W'(QUEUE_DEPTH));
        empty     = (count_cur == '0);

        head_next     = head_cur;
        plan.code     = RES_DONE;
        plan.wr_en    = 1'b0;
        plan.wr_addr  = store_addr(qsel, head_cur);
        plan.wr_data  = {1'b0, tag};
        plan.rd_en    = 1'b0;
        plan.rd_addr  = store_addr(qsel, head_cur);
        plan.fill     = count_cur;

        case (cmd)
            CMD_ADD_TAIL:
            begin
                if (full) begin
                    plan.code = RES_FULL;
                end else begin
                    plan.wr_en   = 1'b1;
                    plan.wr_addr = store_addr(qsel, tail_slot(head_cur, count_cur));
                    plan.wr_data = {1'b0, tag};
                    plan.fill    = count_cur + CNT_W'(1);
                end
            end
            CMD_ADD_HEAD:
            begin
                if (full) begin
                    plan.code = RES_FULL;
                end else begin
                    head_next    = prev_slot(head_cur);
                    plan.wr_en   = 1'b1;
                    plan.wr_addr = store_addr(qsel, head_next);
                    plan.wr_data = {1'b1, tag};
                    plan.fill    = count_cur + CNT_W'(1);
                end
            end
            CMD_SERVE:
            begin
                if (empty) begin
                    plan.code = RES_EMPTY;
                end else begin
                    head_next  = next_slot(head_cur);
                    plan.rd_en = 1'b1;
                    plan.fill  = count_cur - CNT_W'(1);
                end
            end
            default:
            begin
                plan.code = RES_DONE;
            end
        endcase
    end

    // Commit the queue pointer and count when the command advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else if (step) begin
            head_reg[qsel]  <= head_next;
            count_reg[qsel] <= plan.fill;
        end
    end

endmodule
